FILE: hw/rtl/srlm_pkg.sv
package srlm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int SCALED_W   = 16;
  localparam int KEEP_W     = 16;
  localparam int SUM_W      = 38;
  localparam int DVD_W      = 38;
  localparam int DVS_W      = 15;
  localparam int RAD_W      = 30;
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 15;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [KEEP_W-1:0]  KEEP_RESET = 16'd60948;
  localparam logic [LEVEL_W-1:0] FULL_RESET = 15'd5571;

  // configuration register indexes
  localparam logic REG_SMOOTHING_KEEP   = 1'b0;
  localparam logic REG_FULL_SCALE_LEVEL = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: hw/rtl/srlm_if.sv
interface srlm_in_if;
  import srlm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last_in_buffer;

  modport source (output valid, output left_sample, output right_sample,
                  output last_in_buffer, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input last_in_buffer, output ready);
endinterface

interface srlm_out_if;
  import srlm_pkg::*;
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  rms_level;
  logic [LEVEL_W-1:0]  smoothed_level;
  logic [SCALED_W-1:0] scaled_level;

  modport source (output valid, output rms_level, output smoothed_level,
                  output scaled_level, input ready);
  modport sink   (input valid, input rms_level, input smoothed_level,
                  input scaled_level, output ready);
endinterface

FILE: hw/rtl/srlm_div.sv
module srlm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  srlm_pkg::div_req_t        req,
  output logic                      done,
  output logic [srlm_pkg::DVD_W-1:0] quotient
);
  import srlm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // restoring division, one quotient bit per cycle shifted into dvd
  assign shifted  = {rem, dvd[DVD_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DVS_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DVS_W-1:0];
        end
        dvd <= {dvd[DVD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/srlm_sqrt.sv
module srlm_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srlm_pkg::RAD_W-1:0]    radicand,
  output logic                          done,
  output logic [srlm_pkg::LEVEL_W-1:0]  root
);
  import srlm_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = LEVEL_W + 3;

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] rem4;
  logic [REM_W-1:0] trial;

  // digit-by-digit root, one result bit per cycle
  assign rem4  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem4 >= trial) begin
          rem  <= rem4 - trial;
          root <= {root[LEVEL_W-2:0], 1'b1};
        end else begin
          rem  <= rem4;
          root <= {root[LEVEL_W-2:0], 1'b0};
        end
        rad <= {rad[RAD_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/stereo_rms_level_meter_core.sv
// Stereo RMS level meter. Ready is high only in S_IDLE; after a stereo word
// is taken, S_SQ_L and S_SQ_R square and add the halved left and right samples
// on the one shared multiplier. A word marked last_in_buffer then runs the
// end-of-buffer sequence: a shift-subtract divide for the mean square, a
// digit-by-digit root (both skipped for an empty buffer), the multiply states
// S_MUL_OLD and S_MUL_NEW for the smoothing, and a second divide for the
// scaled level. The result sits in an output register; new words are accepted
// while it waits, and only the next end of buffer stalls until it is taken.
// Words beyond MAX_FRAMES in one buffer are left out of the average.
module stereo_rms_level_meter_core #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  srlm_in_if.sink                      sample_in,
  srlm_out_if.source                   level_out,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [srlm_pkg::KEEP_W-1:0]  cfg_data
);
  import srlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_L, S_SQ_R, S_MS_START, S_MS_WAIT, S_RT_START, S_RT_WAIT,
    S_MUL_OLD, S_MUL_NEW, S_SC_START, S_SC_WAIT, S_WRITE
  } state_t;

  state_t state;

  logic [KEEP_W-1:0]         keep;
  logic [LEVEL_W-1:0]        full_scale;
  logic [SUM_W-1:0]          square_sum;
  logic [CNT_W-1:0]          sample_count;
  logic [LEVEL_W-1:0]        smoothed_value;
  logic [LEVEL_W-1:0]        rms;
  logic [MUL_P_W-1:0]        mul_acc;

  logic signed [SAMPLE_W-1:0] left_s;
  logic signed [SAMPLE_W-1:0] right_s;
  logic                       last_s;
  logic                       take_s;

  logic signed [LEVEL_W-1:0] half_l;
  logic signed [LEVEL_W-1:0] half_r;
  logic [LEVEL_W-1:0]        abs_l;
  logic [LEVEL_W-1:0]        abs_r;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        product;
  logic [SUM_W:0]            sum_wide;
  logic [SUM_W-1:0]          sum_next;
  logic [MUL_P_W-1:0]        smooth_sum;
  logic [LEVEL_W-1:0]        fs_eff;

  div_req_t                  div_req;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;
  logic                      rt_start;
  logic                      rt_done;
  logic [LEVEL_W-1:0]        rt_root;

  assign half_l = left_s[SAMPLE_W-1:1];
  assign half_r = right_s[SAMPLE_W-1:1];
  assign abs_l  = half_l[LEVEL_W-1] ? LEVEL_W'(-half_l) : LEVEL_W'(half_l);
  assign abs_r  = half_r[LEVEL_W-1] ? LEVEL_W'(-half_r) : LEVEL_W'(half_r);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_SQ_L: begin
        mul_a = MUL_A_W'(abs_l);
        mul_b = abs_l;
      end
      S_SQ_R: begin
        mul_a = MUL_A_W'(abs_r);
        mul_b = abs_r;
      end
      S_MUL_OLD: begin
        mul_a = MUL_A_W'(keep);
        mul_b = smoothed_value;
      end
      S_MUL_NEW: begin
        mul_a = (MUL_A_W'(1) << KEEP_W) - MUL_A_W'(keep);
        mul_b = rms;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product    = mul_a * mul_b;
  assign sum_wide   = {1'b0, square_sum} + (SUM_W + 1)'(product);
  assign sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign smooth_sum = mul_acc + product;
  assign fs_eff     = (full_scale == '0) ? LEVEL_W'(1) : full_scale;

  always_comb begin
    div_req.start    = (state == S_MS_START) || (state == S_SC_START);
    div_req.dividend = (state == S_SC_START) ? DVD_W'({smoothed_value, 16'h0000})
                                             : square_sum;
    div_req.divisor  = (state == S_SC_START) ? fs_eff
                                             : DVS_W'({sample_count, 1'b0});
  end

  assign rt_start = (state == S_RT_START);

  srlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  srlm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (div_q[RAD_W-1:0]),
    .done     (rt_done),
    .root     (rt_root)
  );

  assign sample_in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      keep            <= KEEP_RESET;
      full_scale      <= FULL_RESET;
      square_sum      <= '0;
      sample_count    <= '0;
      smoothed_value  <= '0;
      level_out.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SMOOTHING_KEEP:   keep       <= cfg_data;
          REG_FULL_SCALE_LEVEL: full_scale <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (level_out.valid && level_out.ready && (state != S_WRITE)) begin
        level_out.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            left_s  <= sample_in.left_sample;
            right_s <= sample_in.right_sample;
            last_s  <= sample_in.last_in_buffer;
            take_s  <= sample_count < CNT_W'(MAX_FRAMES);
            state   <= S_SQ_L;
          end
        end
        S_SQ_L: begin
          if (take_s) begin
            square_sum <= sum_next;
          end
          state <= S_SQ_R;
        end
        S_SQ_R: begin
          if (take_s) begin
            square_sum   <= sum_next;
            sample_count <= sample_count + 1'b1;
          end
          state <= last_s ? S_MS_START : S_IDLE;
        end
        S_MS_START: begin
          // empty buffer gives a zero rms level
          if (sample_count == '0) begin
            rms   <= '0;
            state <= S_MUL_OLD;
          end else begin
            state <= S_MS_WAIT;
          end
        end
        S_MS_WAIT: begin
          if (div_done) begin
            state <= S_RT_START;
          end
        end
        S_RT_START: begin
          state <= S_RT_WAIT;
        end
        S_RT_WAIT: begin
          if (rt_done) begin
            rms   <= rt_root;
            state <= S_MUL_OLD;
          end
        end
        S_MUL_OLD: begin
          mul_acc <= product;
          state   <= S_MUL_NEW;
        end
        S_MUL_NEW: begin
          smoothed_value <= smooth_sum[KEEP_W +: LEVEL_W];
          state          <= S_SC_START;
        end
        S_SC_START: begin
          state <= S_SC_WAIT;
        end
        S_SC_WAIT: begin
          if (div_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (!level_out.valid || level_out.ready) begin
            level_out.valid          <= 1'b1;
            level_out.rms_level      <= rms;
            level_out.smoothed_level <= smoothed_value;
            level_out.scaled_level   <= (div_q[DVD_W-1:SCALED_W] != '0)
                                        ? {SCALED_W{1'b1}} : div_q[SCALED_W-1:0];
            square_sum               <= '0;
            sample_count             <= '0;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/stereo_rms_level_meter_core_tb.sv
`timescale 1ns / 100ps

module stereo_rms_level_meter_core_tb;
  import srlm_pkg::*;

  localparam int MAX_FRAMES = 256;
  localparam longint TIMEOUT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_WORDS = 130;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic [LEVEL_W-1:0]  rms;
    logic [LEVEL_W-1:0]  smoothed;
    logic [SCALED_W-1:0] scaled;
  } levels_t;

  typedef enum int {
    SRC_FULL,
    SRC_EXTREME,
    SRC_QUIET,
    SRC_LOUD
  } source_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SMOOTHING_KEEP;
  logic [KEEP_W-1:0] cfg_data = '0;

  srlm_in_if  sample_in ();
  srlm_out_if level_out ();

  stereo_rms_level_meter_core #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in.sink),
    .level_out (level_out.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // meter state as predicted
  logic [KEEP_W-1:0]  keep_q;
  logic [LEVEL_W-1:0] full_q;
  logic [SUM_W-1:0]   sum_q;
  logic [12:0]        count_q;
  logic [LEVEL_W-1:0] smooth_q;

  levels_t expected_levels[$];
  levels_t head_levels;
  int      error_count = 0;
  int      words_sent = 0;
  int      stall_left = 0;
  bit      steady = 1'b0;
  longint  cycle_count = 0;

  function automatic logic [63:0] halved_square(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W-1:0] h;
    logic signed [31:0] hw;
    logic signed [31:0] p;
    h = s >>> 1;
    hw = h;
    p = hw * hw;
    return 64'(p);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic add_square(input logic [63:0] sq);
    logic [63:0] sum;
    sum = 64'(sum_q) + sq;
    if (sum > SUM_LIMIT) sum = SUM_LIMIT;
    sum_q = sum[SUM_W-1:0];
  endtask

  task automatic predict_levels(input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r,
                                input logic last);
    levels_t lv;
    logic [63:0] rms;
    logic [63:0] mix;
    logic [63:0] fs;
    logic [63:0] scaled;
    if (count_q < MAX_FRAMES) begin
      add_square(halved_square(l));
      add_square(halved_square(r));
      count_q = count_q + 13'd1;
    end
    if (last) begin
      rms = 64'd0;
      if (count_q != 0) rms = root_floor(64'(sum_q) / (64'(count_q) * 64'd2));
      rms = rms & 64'h7FFF;
      mix = (64'(keep_q) * 64'(smooth_q) + (64'd65536 - 64'(keep_q)) * rms) >> 16;
      smooth_q = mix[LEVEL_W-1:0];
      fs = (full_q == 0) ? 64'd1 : 64'(full_q);
      scaled = (64'(smooth_q) << 16) / fs;
      if (scaled > 64'd65535) scaled = 64'd65535;
      lv.rms = rms[LEVEL_W-1:0];
      lv.smoothed = smooth_q;
      lv.scaled = scaled[SCALED_W-1:0];
      expected_levels.push_back(lv);
      sum_q = '0;
      count_q = '0;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r,
                           input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sample_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.left_sample <= l;
    sample_in.right_sample <= r;
    sample_in.last_in_buffer <= last;
    forever begin
      @(posedge clk);
      if (sample_in.ready) break;
    end
    predict_levels(l, r, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    sample_in.valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [KEEP_W-1:0] data);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SMOOTHING_KEEP) keep_q = data;
    else full_q = data[LEVEL_W-1:0];
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input source_kind_t kind);
    logic signed [SAMPLE_W-1:0] s;
    int sel;
    s = SAMPLE_W'($urandom());
    if ($urandom_range(0, 9) == 0) return s;
    case (kind)
      SRC_EXTREME: begin
        sel = $urandom_range(0, 4);
        case (sel)
          0: s = -16'sd32768;
          1: s = 16'sd32767;
          2: s = -16'sd1;
          3: s = 16'sd1;
          default: s = 16'sd0;
        endcase
      end
      SRC_QUIET: s = SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
      SRC_LOUD: begin
        s = SAMPLE_W'($urandom_range(16384, 32767));
        if ($urandom_range(0, 1)) s = -s - 16'sd1;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_buffer(input int len, input source_kind_t kind);
    for (int i = 0; i < len; i++)
      send_word(pick_sample(kind), pick_sample(kind), i == len - 1);
  endtask

  task automatic test_sample_extremes();
    send_word(16'sd32767, 16'sd32767, 1'b1);
    send_word(-16'sd32768, -16'sd32768, 1'b1);
    send_word(16'sd0, 16'sd0, 1'b1);
    send_word(-16'sd1, 16'sd1, 1'b0);
    send_word(16'sd1, -16'sd1, 1'b1);
    send_word(16'sd32767, -16'sd32768, 1'b0);
    send_word(-16'sd32768, 16'sd32767, 1'b0);
    send_word(16'sd0, 16'sd0, 1'b1);
    send_word(16'sh5555, 16'shAAAA, 1'b0);
    send_word(16'shAAAA, 16'sh5555, 1'b1);
    send_word(-16'sd2, 16'sd2, 1'b1);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SMOOTHING_KEEP, 16'd0);
    send_word(-16'sd32768, 16'sd32767, 1'b1);
    send_word(16'sd3, -16'sd3, 1'b1);
    write_reg(REG_SMOOTHING_KEEP, 16'd65535);
    send_word(-16'sd32768, -16'sd32768, 1'b1);
    write_reg(REG_FULL_SCALE_LEVEL, 16'd1);
    send_word(16'sd32767, 16'sd32767, 1'b1);
    write_reg(REG_SMOOTHING_KEEP, 16'd0);
    write_reg(REG_FULL_SCALE_LEVEL, 16'd16384);
    send_word(-16'sd32768, -16'sd32768, 1'b1);
    send_word(16'sd0, 16'sd0, 1'b1);
    write_reg(REG_SMOOTHING_KEEP, KEEP_RESET);
    write_reg(REG_FULL_SCALE_LEVEL, 16'(FULL_RESET));
  endtask

  task automatic test_random_buffers();
    int phase_start;
    int len;
    int pick;
    bit paused;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_SMOOTHING_KEEP, KEEP_W'($urandom_range(0, 65535)));
          write_reg(REG_FULL_SCALE_LEVEL, 16'($urandom_range(1, 16384)));
        end
        2: begin
          write_reg(REG_SMOOTHING_KEEP, 16'd65535);
          write_reg(REG_FULL_SCALE_LEVEL, 16'd1);
        end
        3: begin
          write_reg(REG_SMOOTHING_KEEP, KEEP_W'($urandom_range(0, 65535)));
          write_reg(REG_FULL_SCALE_LEVEL, 16'd16384);
        end
        default: ;
      endcase
      steady = (phase == 1);
      phase_start = words_sent;
      paused = 1'b0;
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(1, 12);
        else if (pick < 95) len = $urandom_range(13, 64);
        else len = $urandom_range(MAX_FRAMES - 6, MAX_FRAMES + 44);
        send_buffer(len, source_kind_t'($urandom_range(0, 3)));
        // hold off until the meter has caught up
        if (!paused && words_sent - phase_start >= PHASE_WORDS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      steady = 1'b0;
    end
    // buffers straddling the frame limit
    send_buffer(MAX_FRAMES, SRC_LOUD);
    send_buffer(MAX_FRAMES + 1, SRC_EXTREME);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      level_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      level_out.ready <= 1'b0;
      stall_left--;
    end else begin
      level_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && level_out.valid && level_out.ready) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result word: rms_level %0d smoothed_level %0d scaled_level %0d",
               level_out.rms_level, level_out.smoothed_level, level_out.scaled_level);
        error_count++;
      end else begin
        head_levels = expected_levels.pop_front();
        if (level_out.rms_level !== head_levels.rms) begin
          $error("rms_level mismatch: expected %0d, actual %0d",
                 head_levels.rms, level_out.rms_level);
          error_count++;
        end
        if (level_out.smoothed_level !== head_levels.smoothed) begin
          $error("smoothed_level mismatch: expected %0d, actual %0d",
                 head_levels.smoothed, level_out.smoothed_level);
          error_count++;
        end
        if (level_out.scaled_level !== head_levels.scaled) begin
          $error("scaled_level mismatch: expected %0d, actual %0d",
                 head_levels.scaled, level_out.scaled_level);
          error_count++;
        end
      end
      stall_left = steady ? 0 : $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sample_in.valid = 1'b0;
    sample_in.left_sample = '0;
    sample_in.right_sample = '0;
    sample_in.last_in_buffer = 1'b0;
    level_out.ready = 1'b0;
    keep_q = KEEP_RESET;
    full_q = FULL_RESET;
    sum_q = '0;
    count_q = '0;
    smooth_q = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_sample_extremes();
    test_register_extremes();
    test_random_buffers();
    drain_results();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
